/* design/sbsp_pkg.sv */
// Shared types, constants and opcode codes of the snooped-bus servo pulse generator.
package sbsp_pkg;

  localparam int CHANNELS     = 4;
  localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W       = 3;
  localparam int PIN_W        = 4;
  localparam int ADDR_W       = 7;
  localparam int DATA_W       = 8;
  localparam int WIDTH_W      = 16;
  localparam int SUM_W        = 11;
  localparam int CNT_W        = 4;
  localparam int FRAME_W      = 8;
  localparam int SCALE_W      = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;
  localparam int SAMPLE_LIMIT = 8;
  localparam int DIVD_W       = SUM_W + 1;
  localparam int REM_W        = 4;
  localparam int DIV_CNT_W    = 4;

  localparam logic [WIDTH_W-1:0] RST_OFF_WIDTH  = 16'd7000;
  localparam logic [WIDTH_W-1:0] RST_MIN_WIDTH  = 16'd7500;
  localparam logic [WIDTH_W-1:0] RST_MAX_WIDTH  = 16'd17500;
  localparam logic [SCALE_W-1:0] RST_SCALE_STEP = 8'd39;
  localparam logic [WIDTH_W-1:0] RST_ENABLE_THR = 16'd2000;
  localparam logic [FRAME_W-1:0] RST_TIMEOUT    = 8'd200;
  localparam logic [ADDR_W-1:0]  RST_ADDR_BASE  = 7'd41;
  localparam logic [WIDTH_W-1:0] RST_SLOT_PER   = 16'd20000;
  localparam logic [FRAME_W-1:0] FRAME_MAX      = 8'hFF;

  typedef enum logic [2:0] {
    OP_ADDR        = 3'd0,
    OP_DATA        = 3'd1,
    OP_STOP        = 3'd2,
    OP_SLOT_START  = 3'd3,
    OP_SLOT_END    = 3'd4,
    OP_KEEPALIVE   = 3'd5
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFF_WIDTH  = 4'd0,
    REG_MIN_WIDTH  = 4'd1,
    REG_MAX_WIDTH  = 4'd2,
    REG_SCALE_STEP = 4'd3,
    REG_ENABLE_THR = 4'd4,
    REG_TIMEOUT    = 4'd5,
    REG_ADDR_BASE  = 4'd6,
    REG_SLOT_PER   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic mul;
    logic wr_width;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_needed;
    logic div_last;
  } dp_sts_t;

  typedef struct packed {
    logic [PIN_W-1:0]   pin_levels;
    logic [WIDTH_W-1:0] off_compare;
    logic [SLOT_W-1:0]  slot_index;
    logic               timed_out;
  } result_t;

endpackage

/* design/sbsp_in_if.sv */
// Input event channel: valid/ready with opcode and snooped bus fields.
interface sbsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  opcode;
  logic [sbsp_pkg::ADDR_W-1:0] bus_address;
  logic [sbsp_pkg::DATA_W-1:0] bus_data;

  modport source (output valid, output opcode, output bus_address, output bus_data,
                  input ready);
  modport sink   (input valid, input opcode, input bus_address, input bus_data,
                  output ready);
endinterface

/* design/sbsp_out_if.sv */
// Result channel: valid/ready with pin levels, compare value, slot and timeout flag.
interface sbsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [sbsp_pkg::PIN_W-1:0]   pin_levels;
  logic [sbsp_pkg::WIDTH_W-1:0] off_compare;
  logic [sbsp_pkg::SLOT_W-1:0]  slot_index;
  logic                         timed_out;

  modport source (output valid, output pin_levels, output off_compare, output slot_index,
                  output timed_out, input ready);
  modport sink   (input valid, input pin_levels, input off_compare, input slot_index,
                  input timed_out, output ready);
endinterface

/* design/sbsp_cfg_if.sv */
// Configuration write channel: valid/ready with register index and write data.
interface sbsp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sbsp_pkg::CFG_IDX_W-1:0]  index;
  logic [sbsp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/snooped_bus_to_servo_pwm.sv */
// Top level of the snooped-bus RC servo pulse generator: controller, datapath, result register.
//
// Turns snooped bus writes and slot timer events into pulse-pin levels for up to
// sbsp_pkg::CHANNELS servo channels. Every accepted event transaction yields exactly one
// result transaction. An address event latches the target; the first data byte after it
// is added to the sum of the addressed channel (at most 8 samples). Slot start raises the
// pin of the current slot when its width exceeds enable_threshold and reports the drop
// compare value (half the slot period when the pin stays low), then advances the slot,
// wrapping after 8 slots, and counts frames; when the frame count passes timeout_frames
// all widths are cleared. Slot end drops all pins and turns the rounded sample average of
// the current slot into a new width. Timing: most events pass through the controller in
// the steps accept, execute and register the result, and the result is registered only
// once the result register is free. A slot end whose channel holds samples also runs the
// rounded average through a restoring divider that retires one quotient bit per cycle over
// 12 bits, followed by a multiply step and a width write-back step. The result
// register lets the next event be accepted while the previous result still waits on the
// output. Input ready is low during reset. Configuration writes are taken in every cycle
// outside reset (cfg ready follows rst_n) and must only be issued while no event is in
// flight.
module snooped_bus_to_servo_pwm (
  input logic          clk,
  input logic          rst_n,
  sbsp_in_if.sink      in_if,
  sbsp_out_if.source   out_if,
  sbsp_cfg_if.sink     cfg_if
);

  sbsp_pkg::ctrl_cmd_t cmd;
  sbsp_pkg::dp_sts_t   sts;
  sbsp_pkg::result_t   res;
  sbsp_pkg::result_t   out_r;
  logic                out_valid_r;
  logic                out_free;
  logic                in_ready;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_if.ready;

  sbsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbsp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_if.opcode),
    .in_bus_address (in_if.bus_address),
    .in_bus_data    (in_if.bus_data),
    .cfg_we         (cfg_if.valid),
    .cfg_index      (cfg_if.index),
    .cfg_data       (cfg_if.data),
    .res            (res)
  );

  assign in_if.ready  = in_ready;
  // drop register writes while reset holds the configuration
  assign cfg_if.ready = rst_n;

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.pin_levels  = out_r.pin_levels;
  assign out_if.off_compare = out_r.off_compare;
  assign out_if.slot_index  = out_r.slot_index;
  assign out_if.timed_out   = out_r.timed_out;

  // a new result is loaded only when the previous one has gone or is leaving
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result loaded over a pending result");

  // an accepted event is executed in the following cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> (cmd.exec && !in_if.ready))
    else $error("accepted event not executed");

  // a timeout clear only happens on the frame wrap
  a_timeout_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.timed_out) |-> (out_if.slot_index == '0))
    else $error("timeout reported away from slot zero");

endmodule

/* design/sbsp_ctrl.sv */
// Controller state machine sequencing one event through the datapath.
module sbsp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  sbsp_pkg::dp_sts_t   sts,
  output sbsp_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_MUL,
    ST_WR,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && in_ready_r) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = sts.div_needed ? ST_DIV : ST_DONE;
      ST_DIV:  if (sts.div_last) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold ready low in reset; raise it on the first cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_ready = in_ready_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid && in_ready_r;
    cmd.exec     = (state_r == ST_EXEC);
    cmd.div_step = (state_r == ST_DIV);
    cmd.mul      = (state_r == ST_MUL);
    cmd.wr_width = (state_r == ST_WR);
    cmd.emit     = (state_r == ST_DONE) && out_free;
  end

endmodule

/* design/sbsp_dp.sv */
// Datapath: configuration, channel state, slot timing, averaging divider and width mapping.
module sbsp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sbsp_pkg::ctrl_cmd_t               cmd,
  output sbsp_pkg::dp_sts_t                 sts,
  input  logic [2:0]                        in_opcode,
  input  logic [sbsp_pkg::ADDR_W-1:0]       in_bus_address,
  input  logic [sbsp_pkg::DATA_W-1:0]       in_bus_data,
  input  logic                              cfg_we,
  input  logic [sbsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbsp_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sbsp_pkg::result_t                 res
);

  localparam int CHANNELS = sbsp_pkg::CHANNELS;
  localparam int CH_W     = sbsp_pkg::CH_W;
  localparam int SLOT_W   = sbsp_pkg::SLOT_W;
  localparam int PIN_W    = sbsp_pkg::PIN_W;
  localparam int ADDR_W   = sbsp_pkg::ADDR_W;
  localparam int DATA_W   = sbsp_pkg::DATA_W;
  localparam int WIDTH_W  = sbsp_pkg::WIDTH_W;
  localparam int SUM_W    = sbsp_pkg::SUM_W;
  localparam int CNT_W    = sbsp_pkg::CNT_W;
  localparam int FRAME_W  = sbsp_pkg::FRAME_W;
  localparam int SCALE_W  = sbsp_pkg::SCALE_W;
  localparam int DIVD_W   = sbsp_pkg::DIVD_W;
  localparam int REM_W    = sbsp_pkg::REM_W;
  localparam int DCNT_W   = sbsp_pkg::DIV_CNT_W;
  localparam logic [SLOT_W:0]   CH_LIMIT   = (SLOT_W+1)'(CHANNELS);
  localparam logic [ADDR_W:0]   CH_SPAN    = (ADDR_W+1)'(CHANNELS);
  localparam logic [CNT_W-1:0]  CNT_LIMIT  = CNT_W'(sbsp_pkg::SAMPLE_LIMIT);
  localparam logic [DCNT_W-1:0] DIV_LAST   = DCNT_W'(DIVD_W - 1);

  // configuration registers
  logic [WIDTH_W-1:0] off_width_r, min_width_r, max_width_r, enable_thr_r, slot_period_r;
  logic [SCALE_W-1:0] scale_step_r;
  logic [FRAME_W-1:0] timeout_r;
  logic [ADDR_W-1:0]  addr_base_r;

  // architectural state
  logic [WIDTH_W-1:0] width_r [CHANNELS];
  logic [SUM_W-1:0]   sum_r   [CHANNELS];
  logic [CNT_W-1:0]   cnt_r   [CHANNELS];
  logic [SLOT_W-1:0]  slot_r;
  logic [FRAME_W-1:0] frame_r;
  logic [ADDR_W-1:0]  lat_addr_r;
  logic               first_r;
  logic [PIN_W-1:0]   pin_r;

  // captured event and per-event results
  logic [2:0]         op_r;
  logic [ADDR_W-1:0]  addr_in_r;
  logic [DATA_W-1:0]  data_in_r;
  logic [WIDTH_W-1:0] compare_r;
  logic               cleared_r;

  // divider and width mapping
  logic [REM_W-1:0]   rem_r;
  logic [DIVD_W-1:0]  quo_r;
  logic [CNT_W-1:0]   div_n_r;
  logic [DCNT_W-1:0]  div_cnt_r;
  logic [WIDTH_W-1:0] prod_r;
  logic               avg_zero_r;

  // address decode
  logic               addr_hit;
  logic [ADDR_W:0]    addr_off;
  logic [CH_W-1:0]    addr_ch;
  logic               slot_valid;
  logic [CH_W-1:0]    slot_ch;
  logic [CH_W-1:0]    sel_ch;
  logic [SUM_W-1:0]   sel_sum;
  logic [CNT_W-1:0]   sel_cnt;
  logic [WIDTH_W-1:0] slot_width;
  logic [SLOT_W-1:0]  slot_inc;
  logic [FRAME_W-1:0] frame_inc;
  logic               timeout_hit;
  logic [REM_W:0]     trial;
  logic               trial_ge;
  logic [WIDTH_W:0]   mapped_sum;
  logic [WIDTH_W-1:0] mapped_width;

  assign addr_off   = {1'b0, lat_addr_r} - {1'b0, addr_base_r};
  assign addr_hit   = (lat_addr_r >= addr_base_r) &&
                      ({1'b0, lat_addr_r} < ({1'b0, addr_base_r} + CH_SPAN));
  assign addr_ch    = addr_off[CH_W-1:0];
  assign slot_valid = {1'b0, slot_r} < CH_LIMIT;
  assign slot_ch    = slot_r[CH_W-1:0];

  // one read port per array: data events use the latched channel, others the slot
  assign sel_ch     = (op_r == sbsp_pkg::OP_DATA) ? addr_ch : slot_ch;
  assign sel_sum    = sum_r[sel_ch];
  assign sel_cnt    = cnt_r[sel_ch];
  assign slot_width = slot_valid ? width_r[slot_ch] : '0;

  assign slot_inc    = slot_r + SLOT_W'(1);
  assign frame_inc   = ((slot_inc == '0) && (frame_r != sbsp_pkg::FRAME_MAX)) ?
                       frame_r + FRAME_W'(1) : frame_r;
  assign timeout_hit = (timeout_r != '0) && (slot_inc == '0) && (frame_inc > timeout_r);

  assign sts.div_needed = (op_r == sbsp_pkg::OP_SLOT_END) && slot_valid && (sel_cnt != '0);
  assign sts.div_last   = (div_cnt_r == DIV_LAST);

  // restoring divide, one quotient bit per step
  assign trial    = {rem_r, quo_r[DIVD_W-1]};
  assign trial_ge = trial >= {1'b0, div_n_r};

  assign mapped_sum   = {1'b0, prod_r} + {1'b0, min_width_r};
  assign mapped_width = avg_zero_r ? off_width_r :
                        (mapped_sum > {1'b0, max_width_r}) ? max_width_r :
                        mapped_sum[WIDTH_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_width_r   <= sbsp_pkg::RST_OFF_WIDTH;
      min_width_r   <= sbsp_pkg::RST_MIN_WIDTH;
      max_width_r   <= sbsp_pkg::RST_MAX_WIDTH;
      scale_step_r  <= sbsp_pkg::RST_SCALE_STEP;
      enable_thr_r  <= sbsp_pkg::RST_ENABLE_THR;
      timeout_r     <= sbsp_pkg::RST_TIMEOUT;
      addr_base_r   <= sbsp_pkg::RST_ADDR_BASE;
      slot_period_r <= sbsp_pkg::RST_SLOT_PER;
    end else if (cfg_we) begin
      unique case (sbsp_pkg::reg_idx_t'(cfg_index))
        sbsp_pkg::REG_OFF_WIDTH:  off_width_r   <= cfg_data;
        sbsp_pkg::REG_MIN_WIDTH:  min_width_r   <= cfg_data;
        sbsp_pkg::REG_MAX_WIDTH:  max_width_r   <= cfg_data;
        sbsp_pkg::REG_SCALE_STEP: scale_step_r  <= cfg_data[SCALE_W-1:0];
        sbsp_pkg::REG_ENABLE_THR: enable_thr_r  <= cfg_data;
        sbsp_pkg::REG_TIMEOUT:    timeout_r     <= cfg_data[FRAME_W-1:0];
        sbsp_pkg::REG_ADDR_BASE:  addr_base_r   <= cfg_data[ADDR_W-1:0];
        sbsp_pkg::REG_SLOT_PER:   slot_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // event capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      addr_in_r <= in_bus_address;
      data_in_r <= in_bus_data;
    end
  end

  // event execution and width write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        width_r[i] <= '0;
        sum_r[i]   <= '0;
        cnt_r[i]   <= '0;
      end
      slot_r     <= '0;
      frame_r    <= '0;
      lat_addr_r <= '0;
      first_r    <= 1'b0;
      pin_r      <= '0;
      compare_r  <= '0;
      cleared_r  <= 1'b0;
    end else if (cmd.exec) begin
      compare_r <= '0;
      cleared_r <= 1'b0;
      unique case (sbsp_pkg::opcode_t'(op_r))
        sbsp_pkg::OP_ADDR: begin
          lat_addr_r <= addr_in_r;
          first_r    <= 1'b0;
        end
        sbsp_pkg::OP_DATA: begin
          if (addr_hit && !first_r) begin
            if (sel_cnt < CNT_LIMIT) begin
              sum_r[sel_ch] <= sel_sum + SUM_W'(data_in_r);
              cnt_r[sel_ch] <= sel_cnt + CNT_W'(1);
            end
            first_r <= 1'b1;
          end
        end
        sbsp_pkg::OP_SLOT_START: begin
          if (slot_width > enable_thr_r) begin
            pin_r     <= pin_r | (PIN_W'(1) << slot_r);
            compare_r <= slot_width;
          end else begin
            compare_r <= slot_period_r >> 1;
          end
          slot_r  <= slot_inc;
          frame_r <= frame_inc;
          if (timeout_hit) begin
            for (int i = 0; i < CHANNELS; i++) width_r[i] <= '0;
            cleared_r <= 1'b1;
          end
        end
        sbsp_pkg::OP_SLOT_END:  pin_r   <= '0;
        sbsp_pkg::OP_KEEPALIVE: frame_r <= '0;
        default:                first_r <= 1'b0;
      endcase
    end else if (cmd.wr_width) begin
      width_r[slot_ch] <= mapped_width;
      sum_r[slot_ch]   <= '0;
      cnt_r[slot_ch]   <= '0;
    end
  end

  // divider and multiplier
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.exec) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rem_r   <= '0;
      quo_r   <= {1'b0, sel_sum} + DIVD_W'(sel_cnt >> 1);
      div_n_r <= sel_cnt;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? REM_W'(trial - {1'b0, div_n_r}) : trial[REM_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], trial_ge};
    end
    if (cmd.mul) begin
      prod_r     <= quo_r[SCALE_W-1:0] * scale_step_r;
      avg_zero_r <= (quo_r[SCALE_W-1:0] == '0);
    end
  end

  assign res.pin_levels  = pin_r;
  assign res.off_compare = compare_r;
  assign res.slot_index  = slot_r;
  assign res.timed_out   = cleared_r;

endmodule
